[rtl/bffa_pkg.sv]
// shared types, constants and status codes of the first-fit bitmap allocator
// no dependencies; imported by every module of the block except bffa_ram
`default_nettype none

package bffa_pkg;

    // map word and field widths
    localparam int unsigned WORD_BITS    = 64;
    localparam int unsigned BIT_W        = 6;
    localparam int unsigned NUM_W        = 14;
    localparam int unsigned STAT_W       = 2;

    // default map capacity and register reset value
    localparam int unsigned DEF_MAP_BITS = 8192;
    localparam int unsigned RESET_SIZE   = 8192;
    localparam int unsigned SIZE_MAX     = 16383;

    localparam logic [NUM_W-1:0] COUNT_MAX = 14'h3FFF;

    // request codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_ALREADY = 2'd3;

    typedef logic [WORD_BITS-1:0] t_word;

    // find-first result
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } t_ffs_res;

endpackage

`default_nettype wire

[rtl/bffa_ram.sv]
// generic single-write, single-read ram with registered read data
// depends on nothing
`default_nettype none

module bffa_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/bffa_ffs.sv]
// find-first-set unit: lowest set bit of one map word
// depends on bffa_pkg
`default_nettype none

module bffa_ffs
    import bffa_pkg::*;
(
    input  wire t_word    i_bits,
    output t_ffs_res      o_res
);

    always_comb begin
        o_res.found = |i_bits;
        o_res.idx   = '0;
        // priority from the top down so the lowest set bit wins
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (i_bits[j]) begin
                o_res.idx = BIT_W'(j);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/bitmap_first_free_allocator_unit.sv]
// top level of the first-fit bitmap allocator: sequencer, count and map ram
// depends on bffa_pkg, bffa_ram, bffa_ffs
`default_nettype none

// First-fit bitmap allocator. The in-use map lives in a ram of 64-bit words
// (MAP_BITS/64 words, 128 by default). After reset the block runs a clearing
// pass that writes one word per cycle with o_ready low; configuration writes
// are taken during it. An allocate request scans the map one word per cycle
// through the ram read port and a single find-first unit; a free request
// reads its word and then checks and clears the bit, and an out-of-range free
// or an allocate on an empty map goes straight to the result. One request is
// worked on at a time. The result sits in an output register, so a new
// request can be taken while the previous result waits. Writing map_size
// reloads the free count with min(map_size, MAP_BITS) and leaves the map as
// it is.
module bitmap_first_free_allocator_unit
    import bffa_pkg::*;
#(
    parameter int unsigned MAP_BITS = DEF_MAP_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request channel
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_func,
    input  wire logic [NUM_W-1:0]  i_entry_number,
    // result channel
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [NUM_W-1:0]  o_granted_number,
    output logic      [STAT_W-1:0] o_status,
    output logic      [NUM_W-1:0]  o_free_left,
    // map_size register
    input  wire logic              i_cfg_wr_en,
    input  wire logic [NUM_W-1:0]  i_cfg_wr_data
);

    // map geometry
    localparam int unsigned NWORDS   = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned AW       = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int unsigned SIZE_CAP = (MAP_BITS < SIZE_MAX) ? MAP_BITS : SIZE_MAX;
    localparam int unsigned RST_EFF  = (MAP_BITS < RESET_SIZE) ? MAP_BITS : RESET_SIZE;

    localparam logic [NUM_W-1:0] CAP       = NUM_W'(SIZE_CAP);
    localparam logic [NUM_W-1:0] RESET_EFF = NUM_W'(RST_EFF);
    localparam logic [NUM_W-1:0] RESET_MAP = NUM_W'(RESET_SIZE);
    localparam logic [AW-1:0]    LAST_WORD = AW'(NWORDS - 1);

    // sequencer states
    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_FREE_RD  = 3'd3;
    localparam logic [2:0] S_FREE_CHK = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    // control registers
    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_chk_addr, n_chk_addr;   // word being checked / cleared
    logic              r_chk_on, n_chk_on;       // read data of r_chk_addr is valid
    logic [NUM_W-1:0]  r_map_size, n_map_size;
    logic [NUM_W-1:0]  r_free_total, n_free_total;
    logic              r_out_valid, n_out_valid;

    // payload registers
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [NUM_W-1:0]  r_res_grant, n_res_grant;
    logic [STAT_W-1:0] r_res_status, n_res_status;
    logic [NUM_W-1:0]  r_out_grant, n_out_grant;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [NUM_W-1:0]  r_out_free, n_out_free;

    // ram port
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    t_word             w_wdata;
    logic [AW-1:0]     w_raddr;
    t_word             w_rdata;

    // datapath
    logic [NUM_W-1:0]  w_eff;
    logic [NUM_W-1:0]  w_cfg_eff;
    logic [NUM_W-1:0]  w_eff_m1;
    logic [31:0]       w_last_full;
    logic [AW-1:0]     w_last;
    logic [31:0]       w_base;
    logic [31:0]       w_rem;
    t_word             w_mask;
    t_word             w_cand;
    t_ffs_res          w_ffs;
    t_word             w_scan_set;
    t_word             w_free_clr;
    logic [NUM_W-1:0]  w_grant;
    logic [NUM_W-1:0]  w_in_idx;
    logic [31:0]       w_in_word_full;
    logic              w_in_bad;
    logic              w_accept;
    logic              w_load_out;

    // effective size is map_size limited to the map capacity
    assign w_eff     = (r_map_size > CAP) ? CAP : r_map_size;
    assign w_cfg_eff = (i_cfg_wr_data > CAP) ? CAP : i_cfg_wr_data;
    assign w_eff_m1  = w_eff - NUM_W'(1);

    // last word holding bits below the size
    assign w_last_full = 32'(w_eff_m1) >> BIT_W;
    assign w_last      = w_last_full[AW-1:0];

    // bits of the checked word that lie below the size
    assign w_base = 32'(r_chk_addr) << BIT_W;
    assign w_rem  = 32'(w_eff) - w_base;
    assign w_mask = (w_rem >= 32'(WORD_BITS)) ? {WORD_BITS{1'b1}}
                  : ((t_word'(1) << w_rem[BIT_W-1:0]) - t_word'(1));
    assign w_cand = ~w_rdata & w_mask;

    bffa_ffs u_ffs (
        .i_bits (w_cand),
        .o_res  (w_ffs)
    );

    assign w_scan_set = w_rdata | (t_word'(1) << w_ffs.idx);
    assign w_free_clr = w_rdata & ~(t_word'(1) << r_bit);
    assign w_grant    = NUM_W'(w_base + 32'(w_ffs.idx) + 32'd1);

    // free request decode
    assign w_in_idx       = i_entry_number - NUM_W'(1);
    assign w_in_word_full = 32'(w_in_idx) >> BIT_W;
    assign w_in_bad       = (i_entry_number == '0) || (i_entry_number > w_eff);

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // scan reads run one word ahead of the check
    always_comb begin
        w_raddr = r_chk_addr;
        if (r_state == S_SCAN) begin
            if (!r_chk_on) begin
                w_raddr = '0;
            end else if (r_chk_addr != w_last) begin
                w_raddr = r_chk_addr + AW'(1);
            end
        end
    end

    bffa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_chk_addr   = r_chk_addr;
        n_chk_on     = r_chk_on;
        n_bit        = r_bit;
        n_map_size   = r_map_size;
        n_free_total = r_free_total;
        n_res_grant  = r_res_grant;
        n_res_status = r_res_status;
        w_we         = 1'b0;
        w_waddr      = r_chk_addr;
        w_wdata      = '0;

        case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                if (r_chk_addr == LAST_WORD) begin
                    n_state = S_IDLE;
                end else begin
                    n_chk_addr = r_chk_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_res_grant  = '0;
                    n_res_status = STAT_OK;
                    n_chk_on     = 1'b0;
                    if (i_func == FUNC_ALLOC) begin
                        n_chk_addr = '0;
                        if (w_eff == '0) begin
                            n_res_status = STAT_FULL;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_chk_addr = w_in_word_full[AW-1:0];
                        n_bit      = w_in_idx[BIT_W-1:0];
                        if (w_in_bad) begin
                            n_res_status = STAT_RANGE;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_FREE_RD;
                        end
                    end
                end
            end
            S_SCAN: begin
                n_chk_on = 1'b1;
                if (r_chk_on) begin
                    if (w_ffs.found) begin
                        // take the lowest free entry
                        w_we        = 1'b1;
                        w_wdata     = w_scan_set;
                        n_res_grant = w_grant;
                        if (r_free_total != '0) begin
                            n_free_total = r_free_total - NUM_W'(1);
                        end
                        n_state = S_DONE;
                    end else if (r_chk_addr == w_last) begin
                        n_res_status = STAT_FULL;
                        n_state      = S_DONE;
                    end else begin
                        n_chk_addr = r_chk_addr + AW'(1);
                    end
                end
            end
            S_FREE_RD: begin
                n_state = S_FREE_CHK;
            end
            S_FREE_CHK: begin
                if (!w_rdata[r_bit]) begin
                    n_res_status = STAT_ALREADY;
                end else begin
                    w_we    = 1'b1;
                    w_wdata = w_free_clr;
                    if (r_free_total != COUNT_MAX) begin
                        n_free_total = r_free_total + NUM_W'(1);
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // register write reloads the count; the user must write only while idle, the block does not enforce it
        if (i_cfg_wr_en) begin
            n_map_size   = i_cfg_wr_data;
            n_free_total = w_cfg_eff;
        end
    end

    // output register
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_grant  = r_out_grant;
        n_out_status = r_out_status;
        n_out_free   = r_out_free;
        if (w_load_out) begin
            n_out_valid  = 1'b1;
            n_out_grant  = r_res_grant;
            n_out_status = r_res_status;
            n_out_free   = r_free_total;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_chk_addr   <= '0;
            r_chk_on     <= 1'b0;
            r_map_size   <= RESET_MAP;
            r_free_total <= RESET_EFF;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_chk_addr   <= n_chk_addr;
            r_chk_on     <= n_chk_on;
            r_map_size   <= n_map_size;
            r_free_total <= n_free_total;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit        <= n_bit;
        r_res_grant  <= n_res_grant;
        r_res_status <= n_res_status;
        r_out_grant  <= n_out_grant;
        r_out_status <= n_out_status;
        r_out_free   <= n_out_free;
    end

    assign o_valid          = r_out_valid;
    assign o_granted_number = r_out_grant;
    assign o_status         = r_out_status;
    assign o_free_left      = r_out_free;

endmodule

`default_nettype wire

[rtl/bffa_checker.sv]
// port-level checks of the first-fit bitmap allocator, bound to the top level
// depends on bffa_pkg and bitmap_first_free_allocator_unit
`default_nettype none

module bffa_checker
    import bffa_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_ready,
    input wire logic              o_valid,
    input wire logic              i_ready,
    input wire logic [NUM_W-1:0]  o_granted_number,
    input wire logic [STAT_W-1:0] o_status,
    input wire logic [NUM_W-1:0]  o_free_left
);

    // reset starts the clearing pass with nothing pending
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_ready && !o_valid))
        else $error("ready or valid right after reset");

    // one request at a time: ready drops after an accepted request
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second request taken while one is in progress");

    // a nonzero grant comes only with status ok, full never grants
    a_grant_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_granted_number == '0) || (o_status == STAT_OK)))
        else $error("grant with non-ok status");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_granted_number)
            && $stable(o_status) && $stable(o_free_left)))
        else $error("stalled result changed");

endmodule

bind bitmap_first_free_allocator_unit bffa_checker u_bffa_checker (.*);

`default_nettype wire

[tb/sv/bffa_response_checker.sv]
`timescale 1ns / 100ps
// response checker for the first-fit bitmap allocator: mirrors the in-use map and free count
// depends on bffa_pkg for field widths, request codes and status codes

module bffa_response_checker
    import bffa_pkg::*;
#(
    parameter int unsigned MAP_BITS = DEF_MAP_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    input  wire logic              i_req_ready,
    input  wire logic              i_func,
    input  wire logic [NUM_W-1:0]  i_entry_number,
    input  wire logic              i_res_valid,
    input  wire logic              i_res_ready,
    input  wire logic [NUM_W-1:0]  i_granted_number,
    input  wire logic [STAT_W-1:0] i_status,
    input  wire logic [NUM_W-1:0]  i_free_left,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [NUM_W-1:0]  i_cfg_wr_data,
    output int                     o_outstanding,
    output int                     o_mismatches
);

    typedef struct packed {
        logic [NUM_W-1:0]  granted;
        logic [STAT_W-1:0] status;
        logic [NUM_W-1:0]  free_left;
    } t_alloc_resp;

    logic [MAP_BITS-1:0] in_use;
    logic [NUM_W-1:0]    free_count;
    logic [NUM_W-1:0]    size_reg;
    t_alloc_resp         owed_responses [$];
    int                  mismatch_count = 0;
    int                  responses_seen = 0;

    assign o_mismatches = mismatch_count;

    // register value clipped to the map capacity
    function automatic int unsigned active_size();
        return (size_reg > MAP_BITS) ? MAP_BITS : size_reg;
    endfunction

    // applies one request to the mirrored map and returns the response it earns
    function automatic t_alloc_resp serve_request(logic func, logic [NUM_W-1:0] num);
        t_alloc_resp resp;
        int unsigned span;
        int unsigned slot;
        bit          hit;
        span        = active_size();
        resp        = '0;
        resp.status = STAT_OK;
        hit         = 1'b0;
        if (func == FUNC_ALLOC) begin
            for (slot = 0; slot < span; slot++) begin
                if (!in_use[slot]) begin
                    hit = 1'b1;
                    break;
                end
            end
            if (hit) begin
                in_use[slot] = 1'b1;
                if (free_count != '0)
                    free_count = free_count - 1'b1;
                resp.granted = NUM_W'(slot + 1);
            end else begin
                resp.status = STAT_FULL;
            end
        end else if (num == '0 || num > span) begin
            resp.status = STAT_RANGE;
        end else if (!in_use[num - 1]) begin
            // count stays put on a double free
            resp.status = STAT_ALREADY;
        end else begin
            in_use[num - 1] = 1'b0;
            if (free_count != COUNT_MAX)
                free_count = free_count + 1'b1;
        end
        resp.free_left = free_count;
        return resp;
    endfunction

    task automatic note_mismatch(string what, t_alloc_resp want, t_alloc_resp got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%0t: response %0d %s: expected granted %0d status %0d free %0d,",
                      " got granted %0d status %0d free %0d"},
                     $realtime, responses_seen, what, want.granted, want.status,
                     want.free_left, got.granted, got.status, got.free_left);
    endtask

    always @(posedge i_clk) begin : watch
        t_alloc_resp want;
        t_alloc_resp got;
        if (!i_rst_n) begin
            in_use     = '0;
            size_reg   = NUM_W'(RESET_SIZE);
            free_count = NUM_W'(active_size());
            owed_responses.delete();
        end else begin
            if (i_cfg_wr_en) begin
                size_reg   = i_cfg_wr_data;
                free_count = NUM_W'(active_size());
            end
            if (i_res_valid && i_res_ready) begin
                responses_seen++;
                got = {i_granted_number, i_status, i_free_left};
                if (owed_responses.size() == 0) begin
                    note_mismatch("with none owed", '0, got);
                end else begin
                    want = owed_responses.pop_front();
                    if (want.granted != got.granted || want.status != got.status
                            || want.free_left != got.free_left)
                        note_mismatch("differs", want, got);
                end
            end
            if (i_req_valid && i_req_ready)
                owed_responses.push_back(serve_request(i_func, i_entry_number));
        end
        o_outstanding <= owed_responses.size();
    end

endmodule

[tb/sv/bitmap_first_free_allocator_unit_tb.sv]
`timescale 1ns / 100ps
// testbench top for the first-fit bitmap allocator: clock, reset, request and response traffic
// depends on bffa_pkg, bffa_response_checker and the allocator rtl

module bitmap_first_free_allocator_unit_tb;
    import bffa_pkg::*;

    localparam int unsigned MAP_BITS     = DEF_MAP_BITS;
    localparam int          RESET_CYCLES = 6;
    // long response hold-off, enough to back the block up into its request port
    localparam int          HOLD_CYCLES  = 400;
    // worst quiet stretch is the hold-off plus a full map scan plus a sender gap
    localparam int          QUIET_LIMIT  = 4000;
    localparam int          PHASE_ITEMS  = 62;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic              i_func;
    logic [NUM_W-1:0]  i_entry_number;
    logic              o_valid;
    logic              i_ready;
    logic [NUM_W-1:0]  o_granted_number;
    logic [STAT_W-1:0] o_status;
    logic [NUM_W-1:0]  o_free_left;
    logic              i_cfg_wr_en;
    logic [NUM_W-1:0]  i_cfg_wr_data;

    int          outstanding;
    int          mismatches;
    int          accepted_requests = 0;
    int          burst_left;
    int unsigned cur_size;

    bitmap_first_free_allocator_unit #(
        .MAP_BITS(MAP_BITS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_entry_number   (i_entry_number),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_granted_number (o_granted_number),
        .o_status         (o_status),
        .o_free_left      (o_free_left),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data)
    );

    bffa_response_checker #(
        .MAP_BITS(MAP_BITS)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_ready      (o_ready),
        .i_func           (i_func),
        .i_entry_number   (i_entry_number),
        .i_res_valid      (o_valid),
        .i_res_ready      (i_ready),
        .i_granted_number (o_granted_number),
        .i_status         (o_status),
        .i_free_left      (o_free_left),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .o_outstanding    (outstanding),
        .o_mismatches     (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // accepted request count, used to time the long hold-off
    always @(posedge i_clk) begin
        if (i_valid && o_ready)
            accepted_requests <= accepted_requests + 1;
    end

    // hold one request on the port until the block takes it; valid is left high
    task automatic offer(logic func, logic [NUM_W-1:0] num);
        i_valid        <= 1'b1;
        i_func         <= func;
        i_entry_number <= num;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // bursts of random length, random gaps between them, sometimes none at all
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // stop sending and wait until every owed response has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // map_size write, only with the block idle; the free count reloads
    task automatic write_size(logic [NUM_W-1:0] value);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_size = (value > MAP_BITS) ? MAP_BITS : value;
    endtask

    // a mix of allocates and frees, the frees mostly of low entries that are likely in use, plus edges and noise
    task automatic random_request();
        logic             func;
        logic [NUM_W-1:0] num;
        int unsigned      pick;
        int unsigned      window;
        func   = ($urandom_range(0, 99) < 55) ? FUNC_ALLOC : FUNC_FREE;
        pick   = $urandom_range(0, 99);
        window = (cur_size < 96) ? cur_size : 96;
        if (pick < 70 && window != 0) begin
            num = NUM_W'($urandom_range(1, window));
        end else if (pick < 85) begin
            case ($urandom_range(0, 2))
                0: num = '0;
                1: num = NUM_W'(cur_size);
                default: num = NUM_W'(cur_size + 1);
            endcase
        end else begin
            num = NUM_W'($urandom);
        end
        pace_sender();
        offer(func, num);
    endtask

    // response side: random stall patterns plus one long hold-off
    initial begin : response_sink
        int mode;
        int stretch;
        int tick;
        bit long_hold_done;
        i_ready        = 1'b0;
        long_hold_done = 1'b0;
        tick           = 0;
        forever begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(10, 150);
            repeat (stretch) begin
                @(posedge i_clk);
                tick++;
                if (!long_hold_done && accepted_requests >= 150) begin
                    // the sender keeps offering, so the block fills and drops o_ready
                    long_hold_done = 1'b1;
                    i_ready <= 1'b0;
                    repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                end else begin
                    case (mode)
                        0: i_ready <= 1'b1;
                        1: i_ready <= 1'($urandom_range(0, 1));
                        2: i_ready <= ($urandom_range(0, 3) == 0);
                        default: i_ready <= ((tick % 5) < 3);
                    endcase
                end
            end
        end
    end

    // ends the run if nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [NUM_W-1:0] phase_sizes [12];
        phase_sizes = '{14'd8, 14'd64, 14'd1, 14'd65, 14'd13, 14'd16383,
                        14'd100, 14'd0, 14'd40, 14'd8192, 14'd127, 14'd5};
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_func         = FUNC_ALLOC;
        i_entry_number = '0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        cur_size       = MAP_BITS;
        burst_left     = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset size: first fit, reuse of a freed hole, double free, range edges
        offer(FUNC_ALLOC, '0);
        offer(FUNC_ALLOC, 14'h3FFF);    // entry field ignored on allocate
        offer(FUNC_ALLOC, '0);
        offer(FUNC_FREE, 14'd2);
        offer(FUNC_FREE, 14'd2);
        offer(FUNC_ALLOC, '0);
        offer(FUNC_FREE, 14'd0);
        offer(FUNC_FREE, 14'd8192);
        offer(FUNC_FREE, 14'd8193);
        offer(FUNC_FREE, 14'h3FFF);

        // empty map: allocate reports full, any free is out of range
        write_size(14'd0);
        offer(FUNC_ALLOC, '0);
        offer(FUNC_FREE, 14'd1);

        // shrink over used entries: count drifts away from the map
        write_size(14'd3);
        offer(FUNC_ALLOC, '0);
        offer(FUNC_FREE, 14'd3);
        offer(FUNC_FREE, 14'd4);
        offer(FUNC_ALLOC, '0);

        // oversize register value clips to the map capacity
        write_size(14'h3FFF);
        offer(FUNC_ALLOC, '0);
        offer(FUNC_FREE, 14'd8192);
        offer(FUNC_FREE, 14'd8193);

        // one-entry map, entries above the size keep their in-use bits
        write_size(14'd1);
        offer(FUNC_ALLOC, '0);
        offer(FUNC_FREE, 14'd1);
        offer(FUNC_ALLOC, '0);
        offer(FUNC_FREE, 14'd2);

        // grow again: the kept bits are still in use
        write_size(14'd8);
        offer(FUNC_FREE, 14'd2);
        offer(FUNC_ALLOC, '0);

        // random phases over a spread of sizes, word boundaries and extremes
        foreach (phase_sizes[p]) begin
            write_size(phase_sizes[p]);
            repeat (PHASE_ITEMS) random_request();
        end

        drain();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/bffa_pkg.sv
rtl/bffa_ram.sv
rtl/bffa_ffs.sv
rtl/bitmap_first_free_allocator_unit.sv
rtl/bffa_checker.sv
tb/sv/bffa_response_checker.sv
tb/sv/bitmap_first_free_allocator_unit_tb.sv
